@@ rtl/core/cspr_pkg.sv @@
// shared constants, types and decode helpers for the can spi register port
package cspr_pkg;

  localparam int REG_COUNT = 128;
  localparam int ADDR_W    = $clog2(REG_COUNT);

  // instruction codes
  localparam logic [7:0] INS_READ   = 8'h03;
  localparam logic [7:0] INS_WRITE  = 8'h02;
  localparam logic [7:0] INS_MODIFY = 8'h05;
  localparam logic [7:0] INS_RESET  = 8'hC0;
  localparam logic [7:0] INS_RX_LO  = 8'h90;
  localparam logic [7:0] INS_RX_HI  = 8'h96;
  localparam logic [7:0] INS_TX_LO  = 8'h40;
  localparam logic [7:0] INS_TX_HI  = 8'h45;

  // register addresses and values
  localparam logic [ADDR_W-1:0] ADDR_CANSTAT = 7'h0E;
  localparam logic [ADDR_W-1:0] ADDR_CANCTRL = 7'h0F;
  localparam logic [ADDR_W-1:0] ADDR_CANINTF = 7'h2C;
  localparam logic [ADDR_W-1:0] RX_BASE      = 7'h61;
  localparam logic [ADDR_W-1:0] TX_BASE      = 7'h31;
  localparam logic [ADDR_W-1:0] BUF_STEP     = 7'h05;
  localparam logic [7:0]        MODE_BITS    = 8'hE0;
  localparam logic [7:0]        MODE_CONFIG  = 8'h80;

  // rx flag pending at frame end
  localparam logic [1:0] RXF_NONE = 2'd0;
  localparam logic [1:0] RXF_RX0  = 2'd1;
  localparam logic [1:0] RXF_RX1  = 2'd2;

  // frame phase
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_ADDR    = 7'b0000010,
    PH_MASK    = 7'b0000100,
    PH_MODDATA = 7'b0001000,
    PH_STREAM  = 7'b0010000,
    PH_IGNORE  = 7'b0100000,
    PH_UNKNOWN = 7'b1000000
  } phase_t;

  // per-beat sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_EX   = 3'b100
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd;
    logic ex;
  } ctl_cmd_t;

  function automatic logic is_rx_read(input logic [7:0] ins);
    return (ins >= INS_RX_LO) && (ins <= INS_RX_HI);
  endfunction

  function automatic logic is_tx_load(input logic [7:0] ins);
    return (ins >= INS_TX_LO) && (ins <= INS_TX_HI);
  endfunction

  // rx buffer start: bit 2 picks the buffer, bit 1 the data start
  function automatic logic [ADDR_W-1:0] rx_start(input logic [7:0] ins);
    logic [ADDR_W-1:0] a;
    a = RX_BASE + {2'b00, ins[2], 4'b0000};
    if (ins[1]) a = a + BUF_STEP;
    return a;
  endfunction

  // tx buffer start: bits 2:1 pick the buffer, bit 0 the data start
  function automatic logic [ADDR_W-1:0] tx_start(input logic [7:0] ins);
    logic [ADDR_W-1:0] a;
    a = TX_BASE + {1'b0, ins[2:1], 4'b0000};
    if (ins[0]) a = a + BUF_STEP;
    return a;
  endfunction

endpackage

@@ rtl/core/cspr_ctrl.sv @@
// beat sequencer: accept, register file read, execute
module cspr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output cspr_pkg::ctl_cmd_t cmd
);

  cspr_pkg::ctl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cspr_pkg::ST_IDLE: if (start) state_nxt = cspr_pkg::ST_RD;
      cspr_pkg::ST_RD:   state_nxt = cspr_pkg::ST_EX;
      cspr_pkg::ST_EX:   state_nxt = cspr_pkg::ST_IDLE;
      default:           state_nxt = cspr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cspr_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // commands to the datapath
  assign busy       = (state_r != cspr_pkg::ST_IDLE);
  assign cmd.accept = start && (state_r == cspr_pkg::ST_IDLE);
  assign cmd.rd     = (state_r == cspr_pkg::ST_RD);
  assign cmd.ex     = (state_r == cspr_pkg::ST_EX);

endmodule

@@ rtl/core/cspr_dp.sv @@
// datapath: frame decode, register file, mirrored status registers, result beat
module cspr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cspr_pkg::ctl_cmd_t cmd,
  input  logic               in_cmd,
  input  logic [7:0]         in_mosi,
  output logic               out_valid,
  output logic [7:0]         out_miso,
  output logic               out_command_unknown
);

  localparam int AW = cspr_pkg::ADDR_W;

  // latched beat
  logic       cmd_r;
  logic [7:0] mosi_r;

  // frame state
  cspr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]    ins_r, ins_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [7:0]    mask_r, mask_nxt;
  logic [1:0]    rxclr_r, rxclr_nxt;

  // registers kept outside the memory
  logic [7:0] canstat_r, canstat_nxt;
  logic [7:0] canintf_r, canintf_nxt;

  // register file with per-entry valid bits
  logic [7:0]           mem [cspr_pkg::REG_COUNT];
  logic [cspr_pkg::REG_COUNT-1:0] vld_r, vld_nxt;
  logic [7:0]           mem_q_r;
  logic                 vld_q_r;

  // result beat
  logic       out_valid_r;
  logic [7:0] out_miso_r, miso_nxt;
  logic       out_unk_r, unk_nxt;

  // store and read data
  logic          st_en;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_data;
  logic          mem_we;
  logic          regs_clr;
  logic [7:0]    rdata;

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_cmd;
      mosi_r <= in_mosi;
    end
  end

  // memory read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mem_q_r <= mem[ptr_r];
      vld_q_r <= vld_r[ptr_r];
    end
  end

  // register view at the pointer
  always_comb begin
    priority if (ptr_r == cspr_pkg::ADDR_CANSTAT) rdata = canstat_r;
    else if (ptr_r == cspr_pkg::ADDR_CANINTF)     rdata = canintf_r;
    else if (vld_q_r)                             rdata = mem_q_r;
    else if (ptr_r == cspr_pkg::ADDR_CANCTRL)     rdata = cspr_pkg::MODE_CONFIG;
    else                                          rdata = 8'h00;
  end

  // frame step
  always_comb begin
    phase_nxt = phase_r;
    ins_nxt   = ins_r;
    ptr_nxt   = ptr_r;
    mask_nxt  = mask_r;
    rxclr_nxt = rxclr_r;
    miso_nxt  = 8'h00;
    unk_nxt   = 1'b0;
    st_en     = 1'b0;
    st_addr   = ptr_r;
    st_data   = mosi_r;
    regs_clr  = 1'b0;
    if (cmd_r) begin
      // frame end
      unk_nxt   = (phase_r == cspr_pkg::PH_UNKNOWN);
      rxclr_nxt = cspr_pkg::RXF_NONE;
      phase_nxt = cspr_pkg::PH_IDLE;
    end else begin
      unique case (phase_r)
        cspr_pkg::PH_IDLE: begin
          ins_nxt = mosi_r;
          priority if (mosi_r == cspr_pkg::INS_RESET) begin
            regs_clr  = 1'b1;
            phase_nxt = cspr_pkg::PH_IGNORE;
          end else if (mosi_r == cspr_pkg::INS_READ || mosi_r == cspr_pkg::INS_WRITE ||
                       mosi_r == cspr_pkg::INS_MODIFY) begin
            phase_nxt = cspr_pkg::PH_ADDR;
          end else if (cspr_pkg::is_rx_read(mosi_r)) begin
            ptr_nxt   = cspr_pkg::rx_start(mosi_r);
            rxclr_nxt = mosi_r[2] ? cspr_pkg::RXF_RX1 : cspr_pkg::RXF_RX0;
            phase_nxt = cspr_pkg::PH_STREAM;
          end else if (cspr_pkg::is_tx_load(mosi_r)) begin
            ptr_nxt   = cspr_pkg::tx_start(mosi_r);
            phase_nxt = cspr_pkg::PH_STREAM;
          end else begin
            phase_nxt = cspr_pkg::PH_UNKNOWN;
            unk_nxt   = 1'b1;
          end
        end
        cspr_pkg::PH_ADDR: begin
          ptr_nxt   = mosi_r[AW-1:0];
          phase_nxt = (ins_r == cspr_pkg::INS_MODIFY) ? cspr_pkg::PH_MASK
                                                      : cspr_pkg::PH_STREAM;
        end
        cspr_pkg::PH_MASK: begin
          mask_nxt  = mosi_r;
          phase_nxt = cspr_pkg::PH_MODDATA;
        end
        cspr_pkg::PH_MODDATA: begin
          st_en     = 1'b1;
          st_data   = (rdata & ~mask_r) | (mosi_r & mask_r);
          phase_nxt = cspr_pkg::PH_IGNORE;
        end
        cspr_pkg::PH_STREAM: begin
          if (ins_r == cspr_pkg::INS_READ || cspr_pkg::is_rx_read(ins_r)) begin
            miso_nxt = rdata;
          end else begin
            st_en = 1'b1;
          end
          ptr_nxt = ptr_r + 1'b1;
        end
        cspr_pkg::PH_UNKNOWN: unk_nxt = 1'b1;
        cspr_pkg::PH_IGNORE:  unk_nxt = 1'b0;
        default:              phase_nxt = cspr_pkg::PH_IDLE;
      endcase
    end
  end

  // register store, canctrl mode mirror, frame-end flag clear, soft reset
  always_comb begin
    canstat_nxt = canstat_r;
    canintf_nxt = canintf_r;
    vld_nxt     = vld_r;
    mem_we      = 1'b0;
    if (regs_clr) begin
      canstat_nxt = cspr_pkg::MODE_CONFIG;
      canintf_nxt = 8'h00;
      vld_nxt     = '0;
    end else if (st_en) begin
      priority if (st_addr == cspr_pkg::ADDR_CANSTAT) begin
        canstat_nxt = st_data;
      end else if (st_addr == cspr_pkg::ADDR_CANINTF) begin
        canintf_nxt = st_data;
      end else begin
        mem_we           = 1'b1;
        vld_nxt[st_addr] = 1'b1;
        if (st_addr == cspr_pkg::ADDR_CANCTRL) begin
          canstat_nxt = (canstat_r & ~cspr_pkg::MODE_BITS) | (st_data & cspr_pkg::MODE_BITS);
        end
      end
    end else if (cmd_r && (rxclr_r == cspr_pkg::RXF_RX0 || rxclr_r == cspr_pkg::RXF_RX1)) begin
      canintf_nxt = canintf_r & ~{6'b000000, rxclr_r};
    end
  end

  // memory write
  always_ff @(posedge clk) begin
    if (cmd.ex && mem_we) mem[st_addr] <= st_data;
  end

  // control and register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cspr_pkg::PH_IDLE;
      ins_r       <= 8'h00;
      ptr_r       <= '0;
      mask_r      <= 8'h00;
      rxclr_r     <= cspr_pkg::RXF_NONE;
      canstat_r   <= cspr_pkg::MODE_CONFIG;
      canintf_r   <= 8'h00;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.ex;
      if (cmd.ex) begin
        phase_r   <= phase_nxt;
        ins_r     <= ins_nxt;
        ptr_r     <= ptr_nxt;
        mask_r    <= mask_nxt;
        rxclr_r   <= rxclr_nxt;
        canstat_r <= canstat_nxt;
        canintf_r <= canintf_nxt;
        vld_r     <= vld_nxt;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (cmd.ex) begin
      out_miso_r <= miso_nxt;
      out_unk_r  <= unk_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_miso            = out_miso_r;
  assign out_command_unknown = out_unk_r;

endmodule

@@ rtl/core/can_controller_spi_register_port.sv @@
// top level of the can controller spi register port
//
//   channel  | handshake          | payload
//   input    | start / busy       | in_cmd, in_mosi
//   result   | out_valid (strobe) | out_miso, out_command_unknown
//
// every beat passes from acceptance to its result strobe through a register file
// read state and an execute state; the strobe then shows the result.
// the register file's single registered read port is why the read has its own state.
// a new beat is taken while the previous result strobe is showing.
// rst_n is synchronous; the register file is cleared through valid bits, no sweep.
// the receiver cannot stall: out_valid is high for exactly one cycle per beat.
module can_controller_spi_register_port (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_cmd,
  input  logic [7:0] in_mosi,
  output logic       out_valid,
  output logic [7:0] out_miso,
  output logic       out_command_unknown
);

  cspr_pkg::ctl_cmd_t cmd;

  // sequencer
  cspr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath
  cspr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_cmd              (in_cmd),
    .in_mosi             (in_mosi),
    .out_valid           (out_valid),
    .out_miso            (out_miso),
    .out_command_unknown (out_command_unknown)
  );

endmodule

@@ rtl/core/cspr_checker.sv @@
// port-level checks for the can spi register port, bound to the top level
module cspr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_cmd,
  input logic       out_valid,
  input logic [7:0] out_miso,
  input logic       out_command_unknown
);

  logic beat_in;
  assign beat_in = start && !busy;

  // each accepted beat yields its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    beat_in |-> ##3 out_valid)
    else $error("result strobe missing after accepted beat");

  // port goes busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    beat_in |=> busy)
    else $error("not busy after accepted beat");

  // no result strobe without a beat in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a beat in flight");

  // a frame-end beat returns zero data
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_in && in_cmd) |-> ##3 (out_miso == 8'h00))
    else $error("frame end returned nonzero data");

  // read data never comes with an unknown instruction flag
  a_unk_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command_unknown) |-> (out_miso == 8'h00))
    else $error("data returned in an unknown frame");

endmodule

bind can_controller_spi_register_port cspr_checker u_cspr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_cmd              (in_cmd),
  .out_valid           (out_valid),
  .out_miso            (out_miso),
  .out_command_unknown (out_command_unknown)
);
